// ----- rtl/cprpl_pkg.sv -----
// Shared types and constants for the code point range property lookup block.
// Used by the controller, the datapath and the top level. No dependencies.

package cprpl_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 1024;
   localparam int unsigned PROP_WIDTH_DEF  = 8;

   localparam int unsigned COUNT_W = 11;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned POINT_W = 32;
   localparam int unsigned PROP_W  = 8;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 11'd2;

   // OR mark of the step halving: (s | 2) >> 1 never drops below 1.
   localparam logic [31:0] HALVE_MARK = 32'h2;

   // Probes allowed beyond the table depth before a lookup gives up.
   localparam int unsigned PROBE_EXTRA = 64;

   typedef enum logic [0:0] {
      REQ_WRITE  = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type        req_type;
      logic [INDEX_W-1:0]  entry_index;
      logic [POINT_W-1:0]  range_first;
      logic [POINT_W-1:0]  range_last;
      logic [PROP_W-1:0]   entry_prop;
      logic [POINT_W-1:0]  code_point;
   } req_beat_type;

   typedef struct packed {
      logic [PROP_W-1:0] property_res;
   } rsp_beat_type;

   typedef logic [COUNT_W-1:0] csr_beat_type;

   typedef struct packed {
      logic start;     // capture code point, set up first probe
      logic wr;        // write one table entry
      logic rd;        // read the probed entry and its neighbors
      logic advance;   // halve step and move the index
      logic res_set;   // capture the lookup result
      logic res_hit;   // result is the probed property, else zero
      logic rsp_load;  // move result into the response register
   } dp_cmd_type;

   typedef struct packed {
      logic limit_hit; // probe budget used up
      logic idx_out;   // probe index not below the entry count
      logic hit;       // probed range contains the code point
      logic stop;      // neighbor check ends the search with zero
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_ISSUE   = 4'b0010,
      S_COMPARE = 4'b0100,
      S_FINISH  = 4'b1000
   } ctrl_state_type;

endpackage

// ----- rtl/cprpl_stream_if.sv -----
// Valid/ready channel interface with a typed payload.
// Used for the request, response and register write channels. No dependencies.

interface cprpl_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ----- rtl/cprpl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; instantiated by the datapath for the range table.

module cprpl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cprpl_dpath.sv -----
// Datapath of the range lookup: entry count register, table memories, probe
// index, step and probe counter, result registers. Depends on cprpl_pkg, cprpl_ram.

module cprpl_dpath
   import cprpl_pkg::*;
#(
   parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
   parameter int unsigned PW    = PROP_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       st,
   input  logic [INDEX_W-1:0]  entry_index,
   input  logic [POINT_W-1:0]  range_first,
   input  logic [POINT_W-1:0]  range_last,
   input  logic [PROP_W-1:0]   entry_prop,
   input  logic [POINT_W-1:0]  code_point,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_data,
   output logic [PROP_W-1:0]   rsp_prop
);

   localparam int unsigned AW          = $clog2(DEPTH);
   localparam int unsigned CW          = $clog2(DEPTH + 1);
   localparam int unsigned IW          = CW + 1;
   localparam int unsigned PROBE_LIMIT = DEPTH + PROBE_EXTRA;
   localparam int unsigned PCW         = $clog2(PROBE_LIMIT + 1);
   localparam int unsigned MW          = 2 * POINT_W + PW;

   function automatic logic [CW-1:0] halve(input logic [CW-1:0] s);
      return (s | CW'(HALVE_MARK)) >> 1;
   endfunction

   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [POINT_W-1:0] cp_ff, cp_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [PCW-1:0]     probes_ff, probes_in;
   logic [PW-1:0]      res_ff, res_in;
   logic [PROP_W-1:0]  rsp_prop_ff, rsp_prop_in;

   logic [31:0]        count_wide;
   logic [CW-1:0]      n_eff;
   logic [CW-1:0]      start_step;
   logic [CW-1:0]      next_step;
   logic [IW-1:0]      idx_next_nb;
   logic [IW-1:0]      idx_prev_nb;
   logic               wr_ok;
   logic [MW-1:0]      main_rd;
   logic [POINT_W-1:0] first_rd, last_rd, first_next_rd, last_prev_rd;
   logic [PW-1:0]      prop_rd;
   logic               below, above;

   // Counts above the table depth act as the table depth.
   assign count_wide = 32'(entry_count_ff);
   assign n_eff      = (count_wide > 32'(DEPTH)) ? CW'(DEPTH) : CW'(count_wide);
   assign start_step = halve(n_eff);
   assign next_step  = halve(step_ff);

   assign idx_next_nb = idx_ff + IW'(1);
   assign idx_prev_nb = idx_ff - IW'(1);
   assign wr_ok       = cmd.wr && (32'(entry_index) < 32'(DEPTH));

   // The main copy holds first, last and property at one address; two more
   // copies serve the right neighbor's first and the left neighbor's last.
   cprpl_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_main_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (AW'(entry_index)),
      .wr_data ({range_first, range_last, PW'(entry_prop)}),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (main_rd)
   );

   cprpl_ram #(.WIDTH(POINT_W), .DEPTH(DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (AW'(entry_index)),
      .wr_data (range_first),
      .rd_en   (cmd.rd),
      .rd_addr (idx_next_nb[AW-1:0]),
      .rd_data (first_next_rd)
   );

   cprpl_ram #(.WIDTH(POINT_W), .DEPTH(DEPTH)) u_last_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (AW'(entry_index)),
      .wr_data (range_last),
      .rd_en   (cmd.rd),
      .rd_addr (idx_prev_nb[AW-1:0]),
      .rd_data (last_prev_rd)
   );

   assign first_rd = main_rd[MW-1 -: POINT_W];
   assign last_rd  = main_rd[PW +: POINT_W];
   assign prop_rd  = main_rd[PW-1:0];

   assign below = cp_ff < first_rd;
   assign above = last_rd < cp_ff;

   always_comb begin
      st.limit_hit = probes_ff == PCW'(PROBE_LIMIT);
      st.idx_out   = idx_ff >= IW'(n_eff);
      st.hit       = !below && !above;
      if (below) begin
         st.stop = (idx_ff == '0) || (last_prev_rd < cp_ff);
      end else begin
         st.stop = (idx_next_nb >= IW'(n_eff)) || (cp_ff < first_next_rd);
      end
   end

   always_comb begin
      entry_count_in = entry_count_ff;
      cp_in          = cp_ff;
      step_in        = step_ff;
      idx_in         = idx_ff;
      probes_in      = probes_ff;
      res_in         = res_ff;
      rsp_prop_in    = rsp_prop_ff;
      if (csr_we) begin
         entry_count_in = csr_data;
      end
      if (cmd.start) begin
         cp_in     = code_point;
         step_in   = start_step;
         idx_in    = IW'(start_step);
         probes_in = '0;
      end
      if (cmd.advance) begin
         step_in   = next_step;
         idx_in    = below ? (idx_ff - IW'(next_step)) : (idx_ff + IW'(next_step));
         probes_in = probes_ff + PCW'(1);
      end
      if (cmd.res_set) begin
         res_in = cmd.res_hit ? prop_rd : '0;
      end
      if (cmd.rsp_load) begin
         rsp_prop_in = PROP_W'(res_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RST;
      end else begin
         entry_count_ff <= entry_count_in;
      end
      cp_ff       <= cp_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      probes_ff   <= probes_in;
      res_ff      <= res_in;
      rsp_prop_ff <= rsp_prop_in;
   end

   assign rsp_prop = rsp_prop_ff;

   a_read_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> idx_ff < IW'(n_eff))
      else $error("table read issued at an index beyond the entry count");

   a_advance_only_on_miss : assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !st.hit && !st.stop)
      else $error("search moved on although the probe ended it");

   a_step_nonzero : assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> step_ff != '0)
      else $error("search step collapsed to zero");

endmodule

// ----- rtl/cprpl_ctrl.sv -----
// Controller of the range lookup: accepts request beats, sequences the probes
// and owns the response valid flag. Depends on cprpl_pkg.

module cprpl_ctrl
   import cprpl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_is_lookup,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type st
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               if (req_is_lookup) begin
                  cmd.start = 1'b1;
                  state_in  = S_ISSUE;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         S_ISSUE: begin
            if (st.limit_hit || st.idx_out) begin
               cmd.res_set = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (st.hit) begin
               cmd.res_set = 1'b1;
               cmd.res_hit = 1'b1;
               state_in    = S_FINISH;
            end else if (st.stop) begin
               cmd.res_set = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_ISSUE;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finish step");

   a_compare_after_issue : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMPARE |-> $past(state_ff == S_ISSUE))
      else $error("compare step without a preceding table read");

   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule

// ----- rtl/code_point_range_property_lookup.sv -----
// Top level of the code point range property lookup: a loadable table of
// sorted ranges searched by halving steps. Depends on cprpl_pkg,
// cprpl_stream_if, cprpl_ctrl, cprpl_dpath and cprpl_ram.
//
//   Channel  Dir  Payload                                   Beat taken when
//   req_ch   in   req_beat_type (write entry or lookup)      valid && ready
//   rsp_ch   out  rsp_beat_type (property_res)               valid && ready
//   csr_ch   in   csr_beat_type (entry_count)                valid && ready
//
// A write beat leaves the controller idle; the next request can follow right after it.
// A lookup beat moves the controller from idle to the issue step. Each compared
// probe is an issue step that reads the table plus a compare step, because the
// next index depends on the registered read data. A probe index outside the
// table or a used-up probe budget goes from the issue step straight to the
// finish step, from which the block returns to idle to take the next request.
// A sorted table of N entries needs about log2(N) + 1 probes.
// Reset (synchronous, active high) sets entry_count to 2 and empties the
// response register; the table contents stay undefined until written. Both
// input channels hold ready low while reset is high.
// A finished result waits in the response register; while it is not taken,
// further write beats are accepted, and a later lookup holds in its finish
// step until the response register frees up.

module code_point_range_property_lookup
   import cprpl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int unsigned PROP_WIDTH  = PROP_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   cprpl_stream_if.sink   req_ch,
   cprpl_stream_if.source rsp_ch,
   cprpl_stream_if.sink   csr_ch
);

   dp_cmd_type        cmd;
   dp_status_type     st;
   logic              req_is_lookup;
   logic              csr_we;
   logic [PROP_W-1:0] rsp_prop;

   // The register port never stalls outside reset; the user must write it only
   // while the block idles, which the block itself does not enforce.
   assign csr_ch.ready = !reset;
   assign csr_we       = csr_ch.valid && !reset;

   assign req_is_lookup = req_ch.payload.req_type == REQ_LOOKUP;

   // The controller decides what happens each cycle; the datapath holds the
   // table, the probe state and the result registers.
   cprpl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_is_lookup (req_is_lookup),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .cmd           (cmd),
      .st            (st)
   );

   cprpl_dpath #(
      .DEPTH (TABLE_DEPTH),
      .PW    (PROP_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .entry_index (req_ch.payload.entry_index),
      .range_first (req_ch.payload.range_first),
      .range_last  (req_ch.payload.range_last),
      .entry_prop  (req_ch.payload.entry_prop),
      .code_point  (req_ch.payload.code_point),
      .csr_we      (csr_we),
      .csr_data    (csr_ch.payload),
      .rsp_prop    (rsp_prop)
   );

   assign rsp_ch.payload.property_res = rsp_prop;

endmodule
